### rtl/rtc3w_pkg.sv
// ----------------------------------------------------------------------------
// rtc3w_pkg
// Shared types and constants of the three-wire RTC serial master: the item
// and result payloads, the configuration bundle and the register indexes.
// ----------------------------------------------------------------------------
package rtc3w_pkg;

  // Command codes carried in the func field.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Configuration register indexes.
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t REG_HALF_PERIOD = 1'd0;
  localparam cfg_idx_t REG_TURNAROUND  = 1'd1;

  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CfgDataWidth-1:0] HALF_PERIOD_RESET = 16'd250;
  localparam logic [CfgDataWidth-1:0] TURNAROUND_RESET  = 16'd500;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] reg_addr;
    logic [6:0] write_value;
    logic       io_in;
  } rtc3w_in_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       rejected;
  } rtc3w_out_t;

  typedef struct packed {
    logic [CfgDataWidth-1:0] half_period_ticks;
    logic [CfgDataWidth-1:0] turnaround_ticks;
  } rtc3w_cfg_t;

endpackage

### rtl/rtc3w_chan_if.sv
// ----------------------------------------------------------------------------
// rtc3w_chan_if
// Valid/ready channel carrying one payload word per transfer.
// ----------------------------------------------------------------------------
interface rtc3w_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/rtc3w_core.sv
// ----------------------------------------------------------------------------
// rtc3w_core
// Pin sequencer of the three-wire master. Holds the transaction state and
// computes the pin levels and status for the tick being stepped.
// ----------------------------------------------------------------------------
module rtc3w_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  rtc3w_pkg::rtc3w_in_t  item_i,
  input  rtc3w_pkg::rtc3w_cfg_t cfg_i,
  output rtc3w_pkg::rtc3w_out_t res_o
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_PRE   = 4'd1,
    PH_HIGH  = 4'd2,
    PH_LOW   = 4'd3,
    PH_POST  = 4'd4,
    PH_TURN  = 4'd5,
    PH_RHIGH = 4'd6,
    PH_RLOW  = 4'd7,
    PH_TAIL  = 4'd8
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  bit_q, bit_d;
  logic        second_q, second_d;
  logic        is_read_q, is_read_d;
  logic [7:0]  shift_out_q, shift_out_d;
  logic [7:0]  shift_in_q, shift_in_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  last_read_q, last_read_d;

  logic        start;
  logic        busy;
  logic [16:0] tick_inc;
  logic [15:0] wait_raw;
  logic [15:0] wait_len;
  logic [2:0]  bit_next;

  // Packed BCD of a value clamped to 99; tens digit by reciprocal multiply.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [6:0]  c;
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    c     = (v > 7'd99) ? 7'd99 : v;
    prod  = 14'(c) * 14'd103;
    tens  = prod[13:10];
    units = c - 7'(tens) * 7'd10;
    return {tens, units[3:0]};
  endfunction

  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'h0, b[3:0]};
  endfunction

  always_comb begin
    phase_d     = phase_q;
    bit_d       = bit_q;
    second_d    = second_q;
    is_read_d   = is_read_q;
    shift_out_d = shift_out_q;
    shift_in_d  = shift_in_q;
    tick_d      = tick_q;
    last_read_d = last_read_q;
    res_o       = '0;

    start = (item_i.func == rtc3w_pkg::FUNC_WRITE) || (item_i.func == rtc3w_pkg::FUNC_READ);

    if (start && phase_q != PH_IDLE) begin
      res_o.rejected = 1'b1;
    end else if (start) begin
      bit_d    = 3'd0;
      second_d = 1'b0;
      tick_d   = 16'd0;
      if (item_i.func == rtc3w_pkg::FUNC_WRITE) begin
        is_read_d   = 1'b0;
        shift_out_d = item_i.reg_addr;
        shift_in_d  = to_bcd(item_i.write_value);
        phase_d     = PH_HIGH;
      end else begin
        is_read_d   = 1'b1;
        shift_out_d = item_i.reg_addr + 8'd1;
        shift_in_d  = 8'd0;
        phase_d     = PH_PRE;
      end
    end

    busy           = (phase_d != PH_IDLE);
    res_o.busy_res = busy;

    // Pin levels follow the phase in effect for this tick.
    unique case (phase_d)
      PH_PRE, PH_TURN, PH_RLOW: begin
        res_o.chip_enable = 1'b1;
      end
      PH_RHIGH: begin
        res_o.chip_enable  = 1'b1;
        res_o.serial_clock = 1'b1;
      end
      PH_HIGH: begin
        res_o.chip_enable  = 1'b1;
        res_o.serial_clock = 1'b1;
        res_o.io_drive     = 1'b1;
        res_o.io_out       = shift_out_d[bit_d];
      end
      PH_LOW, PH_POST: begin
        res_o.chip_enable = 1'b1;
        res_o.io_drive    = 1'b1;
        res_o.io_out      = shift_out_d[bit_d];
      end
      default: begin
      end
    endcase

    wait_raw = (phase_d == PH_TURN) ? cfg_i.turnaround_ticks : cfg_i.half_period_ticks;
    wait_len = (wait_raw == 16'd0) ? 16'd1 : wait_raw;
    tick_inc = {1'b0, tick_d} + 17'd1;
    bit_next = bit_d + 3'd1;

    if (busy) begin
      if (tick_inc >= {1'b0, wait_len}) begin
        tick_d = 16'd0;
        unique case (phase_d)
          PH_PRE:  phase_d = PH_HIGH;
          PH_HIGH: phase_d = PH_LOW;
          PH_LOW: begin
            if (bit_d != 3'd7) begin
              bit_d   = bit_next;
              phase_d = PH_HIGH;
            end else if (is_read_d) begin
              phase_d = PH_POST;
            end else if (!second_d) begin
              second_d    = 1'b1;
              bit_d       = 3'd0;
              shift_out_d = shift_in_d;
              phase_d     = PH_HIGH;
            end else begin
              phase_d        = PH_IDLE;
              res_o.done_res = 1'b1;
            end
          end
          PH_POST: phase_d = PH_TURN;
          PH_TURN: begin
            bit_d      = 3'd0;
            shift_in_d = {7'd0, item_i.io_in};
            phase_d    = PH_RHIGH;
          end
          PH_RHIGH: phase_d = PH_RLOW;
          PH_RLOW: begin
            bit_d      = bit_next;
            shift_in_d = shift_in_d | (8'(item_i.io_in) << bit_next);
            if (bit_next == 3'd7) begin
              last_read_d = shift_in_d;
              phase_d     = PH_TAIL;
            end else begin
              phase_d = PH_RHIGH;
            end
          end
          default: begin
            phase_d        = PH_IDLE;
            res_o.done_res = 1'b1;
          end
        endcase
      end else begin
        tick_d = tick_inc[15:0];
      end
    end

    res_o.read_value = from_bcd(last_read_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_q       <= 3'd0;
      second_q    <= 1'b0;
      is_read_q   <= 1'b0;
      shift_out_q <= 8'd0;
      shift_in_q  <= 8'd0;
      tick_q      <= 16'd0;
      last_read_q <= 8'd0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      bit_q       <= bit_d;
      second_q    <= second_d;
      is_read_q   <= is_read_d;
      shift_out_q <= shift_out_d;
      shift_in_q  <= shift_in_d;
      tick_q      <= tick_d;
      last_read_q <= last_read_d;
    end
  end

endmodule

### rtl/rtc_three_wire_serial_master.sv
// ----------------------------------------------------------------------------
// rtc_three_wire_serial_master
// Three-wire real-time-clock serial master stepped one tick per transfer.
// ----------------------------------------------------------------------------
// Each transfer on req_i is one tick of the pin sequencer and yields exactly
// one result on rsp_o with the pin levels and status for that tick. A tick is
// accepted whenever req_i is ready; its result is registered in the output
// register, and req_i stays ready as long as that register is empty or being
// taken in the same cycle, so the rate is one tick per cycle while rsp_o does
// not stall. Write the timing registers only while no tick is pending.
module rtc_three_wire_serial_master (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  rtc3w_chan_if.sink                                  req_i,
  rtc3w_chan_if.source                                rsp_o,
  input  logic                                        cfg_we_i,
  input  rtc3w_pkg::cfg_idx_t                         cfg_idx_i,
  input  logic [rtc3w_pkg::CfgDataWidth-1:0]          cfg_data_i
);

  rtc3w_pkg::rtc3w_cfg_t cfg_q;
  rtc3w_pkg::rtc3w_out_t res;
  rtc3w_pkg::rtc3w_out_t out_q;
  logic                  out_valid_q;
  logic                  accept;

  assign req_i.ready   = !out_valid_q || rsp_o.ready;
  assign accept        = req_i.valid && req_i.ready;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period_ticks <= rtc3w_pkg::HALF_PERIOD_RESET;
      cfg_q.turnaround_ticks  <= rtc3w_pkg::TURNAROUND_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rtc3w_pkg::REG_HALF_PERIOD: cfg_q.half_period_ticks <= cfg_data_i;
        rtc3w_pkg::REG_TURNAROUND:  cfg_q.turnaround_ticks  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  rtc3w_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .item_i (req_i.payload),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

endmodule

### rtl/rtc3w_checker.sv
// ----------------------------------------------------------------------------
// rtc3w_checker
// Port-level checks of the three-wire master, bound to the top level.
// ----------------------------------------------------------------------------
module rtc3w_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid,
  input logic                  out_ready,
  input rtc3w_pkg::rtc3w_out_t out_payload
);

  // A stalled result must hold its value until it is transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("rtc3w: stalled result changed");

  // The data pin is only pulled high while the block drives it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_payload.io_out |-> out_payload.io_drive)
    else $error("rtc3w: io_out high while data pin released");

  // The serial clock only pulses inside a chip-enable window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_payload.serial_clock |-> out_payload.chip_enable)
    else $error("rtc3w: serial clock outside chip enable");

  // A finishing tick and a rejected command both happen during a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_payload.done_res || out_payload.rejected) |-> out_payload.busy_res)
    else $error("rtc3w: done or rejected without busy");

endmodule

bind rtc_three_wire_serial_master rtc3w_checker u_rtc3w_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (rsp_o.valid),
  .out_ready   (rsp_o.ready),
  .out_payload (rsp_o.payload)
);
